### sv/bilinear_particle_deposit_assert.svh
// Assertion macros for the bilinear particle deposit block.
// Included by bilinear_particle_deposit, the only module that carries concurrent checks; no other dependencies.
`ifndef BILINEAR_PARTICLE_DEPOSIT_ASSERT_SVH
`define BILINEAR_PARTICLE_DEPOSIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPD_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("bpd assertion failed");

// next-cycle implication, disabled in reset
`define BPD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("bpd assertion failed");

`endif

### sv/bpd_pkg.sv
// Package for the bilinear particle deposit block: payload types, codes,
// state encoding and the per-axis split function. No dependencies.
package bpd_pkg;

  localparam int DEF_MESH_WIDTH  = 64;
  localparam int DEF_MESH_HEIGHT = 64;

  // function codes
  localparam logic [1:0] FUNC_DEPOSIT    = 2'd0;
  localparam logic [1:0] FUNC_READ       = 2'd1;
  localparam logic [1:0] FUNC_READ_CLEAR = 2'd2;

  // register indexes
  localparam logic [1:0] REG_INV_W   = 2'd0;
  localparam logic [1:0] REG_INV_H   = 2'd1;
  localparam logic [1:0] REG_WSCALE  = 2'd2;

  localparam logic [31:0] INV_W_RESET  = 32'd65536;
  localparam logic [31:0] INV_H_RESET  = 32'd65536;
  localparam logic [31:0] WSCALE_RESET = 32'd1048576;

  localparam logic [23:0] FRAC_CAP = 24'hFF_FFFF;
  localparam logic signed [50:0] VAL_MAX = 51'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [50:0] VAL_MIN = -51'sh0_8000_0000_0000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [11:0] cell_index;
  } in_t;

  typedef struct packed {
    logic signed [47:0] cell_value;
    logic [11:0]        cell_read;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_MX, ST_MY, ST_SPLITY, ST_PREP,
    ST_WMUL, ST_HMUL, ST_LMUL, ST_SUM, ST_ADD, ST_RDONE
  } state_t;

  typedef struct packed {
    logic [31:0] idx;
    logic [23:0] frac;
  } split_t;

  // clamp the integer part of a Q32.32 coordinate, keep a capped Q.16 fraction
  function automatic split_t axis_split(input logic [63:0] scaled,
                                        input logic [31:0] lim);
    split_t      r;
    logic [31:0] ip;
    logic [31:0] i;
    logic [31:0] d;
    ip = scaled[63:32];
    i  = (ip > lim) ? lim : ip;
    d  = ip - i;
    r.idx  = i;
    r.frac = (d > 32'd255) ? FRAC_CAP : {d[7:0], scaled[31:16]};
    return r;
  endfunction

endpackage

### sv/bpd_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Uses bpd_pkg only by convention; no submodules.
module bpd_mul
  import bpd_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  // one product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

### sv/bilinear_particle_deposit.sv
// Top level of the bilinear particle deposit block: sequencer, mesh memory,
// config registers. Depends on bpd_pkg, bpd_mul and the assertion header.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_data   (in_t)
//  out     | output    | out_valid/out_stall | out_data  (out_t)
//  cfg     | input     | cfg_we              | cfg_addr, cfg_wdata
//
// A deposit runs from acceptance to the next acceptance through these steps:
// the accepting state, x and y axis multiplies, the split/setup states ST_SPLITY and ST_PREP, then per
// corner a weight multiply, two scale multiplies, a sum and a memory read-modify-write,
// all through the one shared multiplier. A read registers its memory read, then ST_RDONE.
// After reset a clearing pass writes zero to all MESH_WIDTH*MESH_HEIGHT cells,
// one per cycle, before the first transaction is taken; config writes are taken anyway.
// A read result waits in the output register while out_stall is high.
`include "bilinear_particle_deposit_assert.svh"

module bilinear_particle_deposit
  import bpd_pkg::*;
#(
  parameter int MESH_WIDTH  = DEF_MESH_WIDTH,
  parameter int MESH_HEIGHT = DEF_MESH_HEIGHT
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int CELLS = MESH_WIDTH * MESH_HEIGHT;
  localparam int XW    = $clog2(MESH_WIDTH);
  localparam int YW    = $clog2(MESH_HEIGHT);
  localparam int CW    = $clog2(CELLS);

  state_t state, state_next;

  logic [31:0] inv_w, inv_h, wscale;

  logic [CW-1:0]  clr_addr;
  logic [1:0]     func_r;
  logic [11:0]    ci_r;
  logic [31:0]    posx_r;
  logic [31:0]    posy_r;
  logic [XW-1:0]  ix;
  logic [YW-1:0]  iy;
  logic [23:0]    fx, fy;
  logic signed [24:0] gx, gy;
  logic [CW-1:0]  base;
  logic [1:0]     corner;
  logic           wneg;
  logic [15:0]    mlo;
  logic [63:0]    hi;
  logic [48:0]    rmag;
  logic [CW-1:0]  cur_addr;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic signed [47:0] mem [CELLS];
  logic signed [47:0] rdata;
  logic [CW-1:0]      mem_raddr, mem_waddr;
  logic               mem_we;
  logic signed [47:0] mem_wdata;

  logic               in_acc;
  logic               ci_ok;
  logic               out_free;
  logic [CW-1:0]      corner_addr;
  logic signed [25:0] a_s, b_s, a_mag, b_mag;
  logic signed [50:0] rsigned, sum;
  split_t             sp;

  assign in_acc   = in_valid && !in_stall;
  assign ci_ok    = 32'(ci_r) < 32'(CELLS);
  assign out_free = !out_valid || !out_stall;
  assign corner_addr = base + (corner[1] ? CW'(MESH_WIDTH) : CW'(0))
                            + CW'(corner[0]);

  bpd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_w  <= INV_W_RESET;
      inv_h  <= INV_H_RESET;
      wscale <= WSCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INV_W:  inv_w  <= cfg_wdata;
        REG_INV_H:  inv_h  <= cfg_wdata;
        REG_WSCALE: wscale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // corner weight operands as signed magnitudes
  always_comb begin
    a_s   = corner[0] ? $signed({2'b00, fx}) : $signed({gx[24], gx});
    b_s   = corner[1] ? $signed({2'b00, fy}) : $signed({gy[24], gy});
    a_mag = a_s[25] ? -a_s : a_s;
    b_mag = b_s[25] ? -b_s : b_s;
    rsigned = $signed({2'b00, rmag});
    sum = 51'(rdata) + (wneg ? -rsigned : rsigned);
    sp  = axis_split(mul_p, (state == ST_MY) ? 32'(MESH_WIDTH - 2)
                                             : 32'(MESH_HEIGHT - 2));
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLR;
    else     state <= state_next;
  end

  // next state, multiplier operands, memory control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    mem_raddr  = CW'(ci_r);
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = 48'sd0;
    case (state)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == CW'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        mem_raddr = CW'(in_data.cell_index);
        if (in_valid) begin
          if (in_data.func == FUNC_DEPOSIT) state_next = ST_MX;
          else if (in_data.func == FUNC_READ || in_data.func == FUNC_READ_CLEAR)
            state_next = ST_RDONE;
        end
      end
      // axis multiplies share the same unit, x split in MY, y split in SPLITY
      ST_MX: begin
        mul_a = posx_r;
        mul_b = inv_w;
        state_next = ST_MY;
      end
      ST_MY: begin
        mul_a = posy_r;
        mul_b = inv_h;
        state_next = ST_SPLITY;
      end
      ST_SPLITY: state_next = ST_PREP;
      ST_PREP:   state_next = ST_WMUL;
      ST_WMUL: begin
        mul_a = 32'(a_mag);
        mul_b = 32'(b_mag);
        state_next = ST_HMUL;
      end
      ST_HMUL: begin
        mul_a = mul_p[47:16];
        mul_b = wscale;
        state_next = ST_LMUL;
      end
      ST_LMUL: begin
        mul_a = {16'd0, mlo};
        mul_b = wscale;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        mem_raddr  = corner_addr;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        mem_we    = 1'b1;
        mem_wdata = (sum > VAL_MAX) ? VAL_MAX[47:0] :
                    (sum < VAL_MIN) ? VAL_MIN[47:0] : sum[47:0];
        state_next = (corner == 2'd3) ? ST_IDLE : ST_WMUL;
      end
      ST_RDONE: begin
        if (out_free) begin
          mem_we     = (func_r == FUNC_READ_CLEAR) && ci_ok;
          mem_waddr  = CW'(ci_r);
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        func_r <= in_data.func;
        ci_r   <= in_data.cell_index;
        posx_r <= in_data.pos_x;
        posy_r <= in_data.pos_y;
      end
      ST_MY: begin
        ix <= XW'(sp.idx);
        fx <= sp.frac;
      end
      ST_SPLITY: begin
        iy <= YW'(sp.idx);
        fy <= sp.frac;
      end
      ST_PREP: begin
        gx     <= 25'sd65536 - $signed({1'b0, fx});
        gy     <= 25'sd65536 - $signed({1'b0, fy});
        base   <= CW'(32'(iy) * 32'(MESH_WIDTH) + 32'(ix));
        corner <= 2'd0;
      end
      ST_WMUL: wneg <= a_s[25] ^ b_s[25];
      ST_HMUL: mlo  <= mul_p[15:0];
      ST_LMUL: hi   <= mul_p;
      ST_SUM: begin
        rmag     <= 49'((65'(hi) + 65'(mul_p[63:16])) >> 16);
        cur_addr <= corner_addr;
      end
      ST_ADD: corner <= corner + 2'd1;
      default: ;
    endcase
  end

  // clearing-pass counter
  always_ff @(posedge clk) begin
    if (rst)                  clr_addr <= '0;
    else if (state == ST_CLR) clr_addr <= clr_addr + CW'(1);
  end

  // mesh memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RDONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RDONE && out_free) begin
      out_data.cell_value <= ci_ok ? rdata : 48'sd0;
      out_data.cell_read  <= ci_r;
    end
  end

  // an accepted deposit goes straight to the x axis multiply
  `BPD_ASSERT_NEXT(a_dep_start, clk, rst,
    in_acc && in_data.func == FUNC_DEPOSIT, state == ST_MX)
  `BPD_ASSERT_IMPLIES(a_clr_stall, clk, rst, state == ST_CLR, in_stall)
  `BPD_ASSERT_NEXT(a_dep_end, clk, rst,
    state == ST_ADD && corner == 2'd3, state == ST_IDLE)
  `BPD_ASSERT_NEXT(a_rd_hold, clk, rst,
    state == ST_RDONE && out_valid && out_stall, state == ST_RDONE)

endmodule

### dv/tb_bilinear_particle_deposit.sv
// Testbench for bilinear_particle_deposit: directed table plus random deposit/read traffic,
// checked against an in-bench mesh accumulator. Depends on bpd_pkg and the block's RTL.
module tb_bilinear_particle_deposit;
  import bpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS     = DEF_MESH_WIDTH * DEF_MESH_HEIGHT;
  localparam int IDX_LIM_X = DEF_MESH_WIDTH - 2;
  localparam int IDX_LIM_Y = DEF_MESH_HEIGHT - 2;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_MIN = -64'sh8000_0000_0000;
  localparam int WATCHDOG  = 20000;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN     = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_INV_W;
  logic [31:0] cfg_wdata = '0;

  bilinear_particle_deposit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // mirror of the mesh and the register file
  longint      mesh_acc[CELLS];
  logic [31:0] inv_w, inv_h, wscale;
  out_t        cell_reads_q[$];
  int          mismatches = 0;
  int          stall_pct = 20;
  int          hold_reqs = 0;
  int          last_base = 0;

  // one axis: clamped cell index and capped Q.16 fraction
  function automatic void split_axis(input logic [31:0] pos, input logic [31:0] inv,
                                     input int lim, output int idx, output longint frac);
    logic [63:0] sc, ip, i, f;
    sc = {32'b0, pos} * {32'b0, inv};
    ip = sc >> 32;
    i  = (ip > 64'(lim)) ? 64'(lim) : ip;
    f  = (sc - (i << 32)) >> 16;
    if (f > 64'hFF_FFFF) f = 64'hFF_FFFF;
    idx  = int'(i);
    frac = longint'(f);
  endfunction

  // Q.32 weight times Q0.32 scale, truncated toward zero
  function automatic longint scaled_weight(input longint w, input logic [31:0] s);
    logic        neg;
    logic [63:0] m, hi, lo, r;
    neg = w < 0;
    m   = neg ? 64'(-w) : 64'(w);
    hi  = (m >> 16) * {32'b0, s};
    lo  = (m & 64'hFFFF) * {32'b0, s};
    r   = (hi + (lo >> 16)) >> 16;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void accumulate(input int idx, input longint v);
    longint sum;
    sum = mesh_acc[idx] + v;
    if (sum > ACC_MAX) sum = ACC_MAX;
    if (sum < ACC_MIN) sum = ACC_MIN;
    mesh_acc[idx] = sum;
  endfunction

  // apply one accepted transaction to the mirror; returns 1 when a read result is due
  function automatic bit mesh_apply(input in_t it, output out_t res);
    int     ix, iy, base;
    longint fx, fy, gx, gy;
    res = '0;
    if (it.func == FUNC_DEPOSIT) begin
      split_axis(it.pos_x, inv_w, IDX_LIM_X, ix, fx);
      split_axis(it.pos_y, inv_h, IDX_LIM_Y, iy, fy);
      gx = 65536 - fx;
      gy = 65536 - fy;
      base = iy * DEF_MESH_WIDTH + ix;
      last_base = base;
      accumulate(base, scaled_weight(gx * gy, wscale));
      accumulate(base + 1, scaled_weight(fx * gy, wscale));
      accumulate(base + DEF_MESH_WIDTH, scaled_weight(gx * fy, wscale));
      accumulate(base + DEF_MESH_WIDTH + 1, scaled_weight(fx * fy, wscale));
      return 1'b0;
    end
    if (it.func == FUNC_READ || it.func == FUNC_READ_CLEAR) begin
      res.cell_read = it.cell_index;
      if (int'(it.cell_index) < CELLS) begin
        res.cell_value = mesh_acc[it.cell_index][47:0];
        if (it.func == FUNC_READ_CLEAR) mesh_acc[it.cell_index] = 0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one transaction, record its expected read result once it is taken
  task automatic offer(input in_t it, input bit known, input longint kv, input bit no_gap);
    out_t res;
    int   gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (mesh_apply(it, res)) begin
      if (known) res.cell_value = kv[47:0];
      cell_reads_q.push_back(res);
    end
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one write cycle, then the enable is driven low before the task returns
  task automatic reg_write(input logic [1:0] addr, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_INV_W:  inv_w  = val;
      REG_INV_H:  inv_h  = val;
      REG_WSCALE: wscale = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // block is idle: no result pending and any deposit has had time to finish
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (cell_reads_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic in_t mk(input logic [1:0] f, input logic [31:0] x,
                             input logic [31:0] y, input logic [11:0] ci);
    in_t it;
    it.func = f;
    it.pos_x = x;
    it.pos_y = y;
    it.cell_index = ci;
    return it;
  endfunction

  function automatic in_t rand_item();
    int   r;
    in_t  it;
    r = $urandom_range(0, 99);
    it = mk(FUNC_DEPOSIT, $urandom, $urandom, 12'($urandom_range(0, CELLS - 1)));
    // positions mostly inside the mesh under unit cell size
    if ($urandom_range(0, 3) != 0) begin
      it.pos_x = $urandom_range(0, DEF_MESH_WIDTH << 16);
      it.pos_y = $urandom_range(0, DEF_MESH_HEIGHT << 16);
    end
    if (r < 50) it.func = FUNC_DEPOSIT;
    else if (r < 72) it.func = FUNC_READ;
    else if (r < 95) it.func = FUNC_READ_CLEAR;
    else it.func = 2'd3;
    // reads mostly near recent deposits
    if (r >= 50 && $urandom_range(0, 2) != 0)
      it.cell_index = 12'(last_base + (($urandom_range(0, 1) != 0) ? DEF_MESH_WIDTH : 0)
                          + $urandom_range(0, 1));
    return it;
  endfunction

  typedef struct {
    in_t    item;
    bit     known;
    longint value;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(input in_t it, input bit known, input longint kv);
    stim_row_t row;
    row.item = it;
    row.known = known;
    row.value = kv;
    directed.push_back(row);
  endtask

  // receiver: random stall, occasional long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_seen + 1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_left <= $urandom_range(15, 50);
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // compare each read result with the oldest expectation
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (cell_reads_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected read result: cell %0d value %0d",
                   out_data.cell_read, out_data.cell_value);
      end else begin
        exp_res = cell_reads_q.pop_front();
        if (out_data.cell_value !== exp_res.cell_value ||
            out_data.cell_read !== exp_res.cell_read) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read mismatch: exp cell %0d value %0d, got cell %0d value %0d",
                     exp_res.cell_read, exp_res.cell_value,
                     out_data.cell_read, out_data.cell_value);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] settings[5][3];
    for (int i = 0; i < CELLS; i++) mesh_acc[i] = 0;
    inv_w  = INV_W_RESET;
    inv_h  = INV_H_RESET;
    wscale = WSCALE_RESET;

    // directed table, default registers
    add_row(mk(FUNC_READ, 0, 0, 12'd0), 1, 0);
    add_row(mk(FUNC_READ, 0, 0, 12'd4095), 1, 0);
    add_row(mk(FUNC_DEPOSIT, 0, 0, 12'd0), 0, 0);
    add_row(mk(FUNC_READ, 0, 0, 12'd0), 1, 1048576);
    add_row(mk(FUNC_READ_CLEAR, 0, 0, 12'd0), 1, 1048576);
    add_row(mk(FUNC_READ, 0, 0, 12'd0), 1, 0);
    add_row(mk(FUNC_DEPOSIT, 32'h8000, 32'h8000, 12'd0), 0, 0);
    add_row(mk(FUNC_READ, 0, 0, 12'd65), 1, 262144);
    // beyond the far edge: fraction capped, weights leave 0..1
    add_row(mk(FUNC_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd0), 0, 0);
    add_row(mk(FUNC_READ_CLEAR, 0, 0, 12'd4030), 0, 0);
    add_row(mk(FUNC_READ_CLEAR, 0, 0, 12'd4031), 0, 0);
    add_row(mk(FUNC_READ_CLEAR, 0, 0, 12'd4094), 0, 0);
    add_row(mk(FUNC_READ_CLEAR, 0, 0, 12'd4095), 0, 0);
    // exactly on the last grid line: all weight lands on the corner cell
    add_row(mk(FUNC_DEPOSIT, 32'h003F_0000, 32'h003F_0000, 12'd0), 0, 0);
    add_row(mk(FUNC_READ, 0, 0, 12'd4095), 1, 1048576);
    add_row(mk(FUNC_READ, 0, 0, 12'd4094), 1, 0);
    // unused code is dropped
    add_row(mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF), 0, 0);
    add_row(mk(FUNC_DEPOSIT, 32'h0002_4000, 32'h0001_C000, 12'd0), 0, 0);
    add_row(mk(FUNC_READ_CLEAR, 0, 0, 12'd1), 0, 0);
    add_row(mk(FUNC_READ_CLEAR, 0, 0, 12'd64), 0, 0);
    add_row(mk(FUNC_READ_CLEAR, 0, 0, 12'd65), 0, 0);
    add_row(mk(FUNC_READ, 0, 0, 12'd130), 0, 0);

    // register settings per phase: defaults, largest, zero, random, fractional axis scales
    settings[0] = '{INV_W_RESET, INV_H_RESET, WSCALE_RESET};
    settings[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    settings[2] = '{32'h0, 32'h0, 32'h0};
    settings[3] = '{$urandom_range(32'h4000, 32'h4_0000), $urandom_range(32'h4000, 32'h4_0000),
                    $urandom};
    settings[4] = '{32'h0001_8000, 32'h0000_C000, 32'h8000_0000};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer(directed[i].item, directed[i].known, directed[i].value, 0);

    for (int ph = 0; ph < 5; ph++) begin
      drain_idle();
      for (int r = 0; r < 3; r++) reg_write(2'(r), settings[ph][r]);
      if (ph == 2) reg_write(2'd3, $urandom);
      stall_pct = (ph == 3) ? 0 : 20 + 10 * ph;
      // long receiver hold-off while the sender keeps offering reads
      if (ph == 1) begin
        hold_reqs++;
        for (int k = 0; k < 30; k++)
          offer(mk(FUNC_READ, $urandom, $urandom, 12'($urandom)), 0, 0, 1);
      end
      for (int k = 0; k < 200; k++) begin
        offer(rand_item(), 0, 0, 0);
        // sender waits out every pending result once, midway through the phase
        if (k == 100) begin
          in_valid <= 1'b0;
          while (cell_reads_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
      // heavy saturation at the largest setting
      if (ph == 1)
        for (int k = 0; k < 20; k++) begin
          offer(mk(FUNC_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 0, 0, 0);
          offer(mk(FUNC_READ, 0, 0, 12'd4030 + 12'($urandom_range(0, 1))), 0, 0, 0);
        end
    end

    drain_idle();
    if (mismatches == 0 && cell_reads_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/bpd_pkg.sv
sv/bpd_mul.sv
sv/bilinear_particle_deposit.sv
dv/tb_bilinear_particle_deposit.sv
